// ===== rtl/divisor_count_sqrt_bound_defines.svh =====
// Assertion macros shared by the divisor count block.
// Depends on nothing; included by the modules that carry assertions.
`ifndef DIVISOR_COUNT_SQRT_BOUND_DEFINES_SVH
`define DIVISOR_COUNT_SQRT_BOUND_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DCSB_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dcsb assertion failed");

// Next-cycle implication, checked outside reset.
`define DCSB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dcsb assertion failed");

`endif

// ===== rtl/dcsb_pkg.sv =====
// Shared constants and types for the divisor count block.
// Depends on nothing; used by every module of the block.
package dcsb_pkg;

    localparam int FIELD_WIDTH         = 32;
    localparam int VALUE_WIDTH_DEFAULT = 32;
    localparam int DATA_WIDTH_DEFAULT  = 32;
    localparam int ROOT_WIDTH_DEFAULT  = 16;
    localparam int COUNT_WIDTH         = 11;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_CHECK,
        ST_DIV,
        ST_FINISH
    } state_t;

    // Status returned by an iterative unit.
    typedef struct packed {
        logic done;
        logic zero_rem;
    } unit_status_t;

endpackage

// ===== rtl/divisor_count_sqrt_bound.sv =====
// Top level of the divisor count block: sequencer, count and output register.
// Depends on dcsb_pkg, dcsb_sqrt, dcsb_rem and divisor_count_sqrt_bound_defines.svh.
//
// Usage: one 32-bit word enters on s_value/s_valid/s_ready; one word leaves on
// m_divisor_count/m_valid/m_ready with the number of positive divisors of the
// low VALUE_WIDTH bits (capped at 32) of the input, 0 for an input of zero.
// The block first takes the exact integer root r with a two-bits-per-cycle
// root unit, then runs trial divisors 1..r one after another through a shared
// bit-serial remainder unit, adding two per exact division and removing one
// when the value is a perfect square.
// The trial loop runs r divisors, up to r = 65535 for W = 32 data bits.
// One word is processed at a time: s_ready is high only while the sequencer
// is idle, so s_ready rises together with m_valid.
// The finished result sits in an output register, so a new word can be
// taken while m_valid waits on a stalled receiver; the block then stops at
// the end of that word until the register frees up.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops
// m_valid; no pending result survives it.
`include "divisor_count_sqrt_bound_defines.svh"

module divisor_count_sqrt_bound #(
    parameter int VALUE_WIDTH = dcsb_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [dcsb_pkg::FIELD_WIDTH-1:0]  s_value,
    input  logic                              s_valid,
    output logic                              s_ready,
    output logic [dcsb_pkg::COUNT_WIDTH-1:0]  m_divisor_count,
    output logic                              m_valid,
    input  logic                              m_ready
);

    localparam int DataWidth = (VALUE_WIDTH < dcsb_pkg::FIELD_WIDTH)
                             ? VALUE_WIDTH : dcsb_pkg::FIELD_WIDTH;
    localparam int RootWidth = (DataWidth + 1) / 2;
    localparam int CW        = dcsb_pkg::COUNT_WIDTH;

    dcsb_pkg::state_t state_reg, state_next;

    logic [DataWidth-1:0] held_value_reg, held_value_next;
    logic [RootWidth-1:0] root_reg, root_next;
    logic [RootWidth:0]   trial_reg, trial_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 exact_reg, exact_next;
    logic                 m_valid_reg, m_valid_next;
    logic [CW-1:0]        m_count_reg, m_count_next;

    logic                   sqrt_start;
    logic                   rem_start;
    logic [RootWidth-1:0]   sqrt_root;
    dcsb_pkg::unit_status_t sqrt_status;
    dcsb_pkg::unit_status_t rem_status;
    logic [CW-1:0]          count_inc;
    logic [CW-1:0]          count_final;

    dcsb_sqrt #(
        .DATA_WIDTH (DataWidth),
        .ROOT_WIDTH (RootWidth)
    ) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .operand (s_value[DataWidth-1:0]),
        .root    (sqrt_root),
        .status  (sqrt_status)
    );

    dcsb_rem #(
        .DATA_WIDTH (DataWidth),
        .ROOT_WIDTH (RootWidth)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (held_value_reg),
        .divisor  (trial_reg[RootWidth-1:0]),
        .status   (rem_status)
    );

    // Saturating add of two; never reached for 32-bit values.
    assign count_inc = (count_reg >= dcsb_pkg::COUNT_MAX - CW'(1))
                     ? dcsb_pkg::COUNT_MAX : count_reg + CW'(2);
    // A perfect square counted its root twice.
    assign count_final = (exact_reg && (count_reg != '0)) ? count_reg - CW'(1) : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dcsb_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_value_reg <= '0;
            root_reg       <= '0;
            trial_reg      <= '0;
            count_reg      <= '0;
            exact_reg      <= 1'b0;
            m_count_reg    <= '0;
        end else begin
            held_value_reg <= held_value_next;
            root_reg       <= root_next;
            trial_reg      <= trial_next;
            count_reg      <= count_next;
            exact_reg      <= exact_next;
            m_count_reg    <= m_count_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        held_value_next = held_value_reg;
        root_next       = root_reg;
        trial_next      = trial_reg;
        count_next      = count_reg;
        exact_next      = exact_reg;
        m_valid_next    = m_valid_reg;
        m_count_next    = m_count_reg;
        sqrt_start      = 1'b0;
        rem_start       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            dcsb_pkg::ST_IDLE: begin
                if (s_valid) begin
                    held_value_next = s_value[DataWidth-1:0];
                    sqrt_start      = 1'b1;
                    state_next      = dcsb_pkg::ST_SQRT;
                end
            end
            dcsb_pkg::ST_SQRT: begin
                if (sqrt_status.done) begin
                    root_next  = sqrt_root;
                    exact_next = sqrt_status.zero_rem;
                    trial_next = (RootWidth+1)'(1);
                    count_next = '0;
                    state_next = dcsb_pkg::ST_CHECK;
                end
            end
            dcsb_pkg::ST_CHECK: begin
                if (trial_reg > {1'b0, root_reg}) begin
                    state_next = dcsb_pkg::ST_FINISH;
                end else begin
                    rem_start  = 1'b1;
                    state_next = dcsb_pkg::ST_DIV;
                end
            end
            dcsb_pkg::ST_DIV: begin
                if (rem_status.done) begin
                    if (rem_status.zero_rem) begin
                        count_next = count_inc;
                    end
                    trial_next = trial_reg + (RootWidth+1)'(1);
                    state_next = dcsb_pkg::ST_CHECK;
                end
            end
            dcsb_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_count_next = count_final;
                    state_next   = dcsb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dcsb_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_ready         = (state_reg == dcsb_pkg::ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_divisor_count = m_count_reg;

    `DCSB_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `DCSB_ASSERT_NOW(a_sqrt_done_in_sqrt, aclk, aresetn, sqrt_status.done,
        state_reg == dcsb_pkg::ST_SQRT)
    `DCSB_ASSERT_NOW(a_rem_done_in_div, aclk, aresetn, rem_status.done,
        state_reg == dcsb_pkg::ST_DIV)
    `DCSB_ASSERT_NOW(a_trial_in_range, aclk, aresetn, state_reg == dcsb_pkg::ST_DIV,
        (trial_reg <= {1'b0, root_reg}) && (trial_reg != '0))

endmodule

// ===== rtl/dcsb_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Depends on dcsb_pkg.
module dcsb_sqrt #(
    parameter int DATA_WIDTH = dcsb_pkg::DATA_WIDTH_DEFAULT,
    parameter int ROOT_WIDTH = dcsb_pkg::ROOT_WIDTH_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [DATA_WIDTH-1:0]     operand,
    output logic [ROOT_WIDTH-1:0]     root,
    output dcsb_pkg::unit_status_t    status
);

    localparam int CntWidth = $clog2(ROOT_WIDTH + 1);

    logic [2*ROOT_WIDTH-1:0] rad_reg;
    logic [ROOT_WIDTH:0]     rem_reg;
    logic [ROOT_WIDTH-1:0]   root_reg;
    logic [CntWidth-1:0]     cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic [ROOT_WIDTH+1:0] rem_sh;
    logic [ROOT_WIDTH+1:0] trial;
    logic [ROOT_WIDTH+1:0] diff;
    logic                  fits;

    // One digit of the classic restoring root: compare 4*rem+digits with 4*root+1.
    assign rem_sh = {rem_reg[ROOT_WIDTH-1:0], rad_reg[2*ROOT_WIDTH-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CntWidth'(1));
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == CntWidth'(1))) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= (2*ROOT_WIDTH)'(operand);
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= CntWidth'(ROOT_WIDTH);
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[2*ROOT_WIDTH-3:0], 2'b00};
            rem_reg  <= fits ? diff[ROOT_WIDTH:0] : rem_sh[ROOT_WIDTH:0];
            root_reg <= {root_reg[ROOT_WIDTH-2:0], fits};
            cnt_reg  <= cnt_reg - CntWidth'(1);
        end
    end

    assign root            = root_reg;
    assign status.done     = done_reg;
    assign status.zero_rem = (rem_reg == '0);

endmodule

// ===== rtl/dcsb_rem.sv =====
// Iterative restoring remainder, one dividend bit per cycle.
// Depends on dcsb_pkg.
module dcsb_rem #(
    parameter int DATA_WIDTH = dcsb_pkg::DATA_WIDTH_DEFAULT,
    parameter int ROOT_WIDTH = dcsb_pkg::ROOT_WIDTH_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [DATA_WIDTH-1:0]     dividend,
    input  logic [ROOT_WIDTH-1:0]     divisor,
    output dcsb_pkg::unit_status_t    status
);

    localparam int CntWidth = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] dvd_reg;
    logic [ROOT_WIDTH-1:0] div_reg;
    logic [ROOT_WIDTH-1:0] rem_reg;
    logic [CntWidth-1:0]   cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [ROOT_WIDTH:0] rem_sh;
    logic [ROOT_WIDTH:0] div_ext;
    logic [ROOT_WIDTH:0] diff;
    logic                fits;

    assign rem_sh  = {rem_reg, dvd_reg[DATA_WIDTH-1]};
    assign div_ext = {1'b0, div_reg};
    assign fits    = rem_sh >= div_ext;
    assign diff    = rem_sh - div_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CntWidth'(1));
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == CntWidth'(1))) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // The partial remainder stays below the divisor, so it fits the root width.
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
            cnt_reg <= CntWidth'(DATA_WIDTH);
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DATA_WIDTH-2:0], 1'b0};
            rem_reg <= fits ? diff[ROOT_WIDTH-1:0] : rem_sh[ROOT_WIDTH-1:0];
            cnt_reg <= cnt_reg - CntWidth'(1);
        end
    end

    assign status.done     = done_reg;
    assign status.zero_rem = (rem_reg == '0);

endmodule
